@@ hw/rtl/b64sc_pkg.sv @@
// ----------------------------------------------------------------------------
// b64sc_pkg: shared types and constants of the base64 stream codec
// Item formats, the job record passed from front to back, alphabet mapping.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  // mode register codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // special characters
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } src_item_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_length;
  } res_item_t;

  // one group of work for the back end
  typedef struct packed {
    logic [23:0] bits;       // group bits, first item highest
    logic [1:0]  last_idx;   // number of results minus one
    logic        enc;        // results are alphabet characters
    logic [1:0]  pad;        // [1]: third char is '=', [0]: fourth char is '='
    logic        last;       // group ends the stream
    logic        bad;        // error result for a short decode stream
  } job_t;

  // sextet to alphabet character
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = {2'b00, v} + 8'd65;
    end else if (v < 6'd52) begin
      c = {2'b00, v} + 8'd71;
    end else if (v < SEXTET_PLUS) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == SEXTET_PLUS) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  // alphabet character to sextet, anything else to zero
  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c == CHAR_PLUS) begin
      t = {2'b00, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      t = {2'b00, SEXTET_SLASH};
    end else if (c inside {[8'h30:8'h39]}) begin
      t = c + 8'd4;
    end else if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'd65;
    end else if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'd71;
    end
    return t[5:0];
  endfunction

endpackage

@@ hw/rtl/base64_stream_codec.sv @@
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder and decoder
// Front gathers groups, a job queue decouples it from the result emitter.
// ----------------------------------------------------------------------------
// Usage:
//   mode_we / mode_wdata write the mode (0 encode, 1 decode); any write also
//   drops a partly gathered group. Write only while the block is idle.
//   Input side is a queue: an item is taken when push is high and full low.
//   source.in_last marks the final item of a stream.
//   Result side is a queue: result holds the oldest item while empty is low,
//   and it is taken when pop is high.
//   A group's job enters the job queue when the item completing it is taken;
//   its first result then passes into the output register once that is free.
//   Throughput: one input item per cycle while the job queue has room, one
//   result per cycle out of the output register while the receiver pops.
//   Encode gives four results per three items, so a long encode stream is
//   bound by the single result port; decode runs at one item a cycle.
//   When the receiver stalls, results wait in the output register, jobs pile
//   up in the job queue (QUEUE_DEPTH groups) and then full rises.
//   Reset (synchronous, rst high) empties both sides and sets encode mode.
// ----------------------------------------------------------------------------
module base64_stream_codec
  import b64sc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      mode_we,
  input  logic      mode_wdata,
  input  logic      push,
  output logic      full,
  input  src_item_t source,
  output logic      empty,
  input  logic      pop,
  output res_item_t result
);

  logic mode;
  logic accept;
  logic job_push;
  job_t wr_job;
  logic job_pop;
  logic head_valid;
  job_t head;

  assign accept = push && !full;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
    end else if (mode_we) begin
      mode <= mode_wdata;
    end
  end

  b64sc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .clear    (mode_we),
    .accept   (accept),
    .source   (source),
    .job_push (job_push),
    .job      (wr_job)
  );

  b64sc_job_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .wr_job     (wr_job),
    .full       (full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64sc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .job_pop    (job_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

@@ hw/rtl/b64sc_front.sv @@
// ----------------------------------------------------------------------------
// b64sc_front: group gatherer
// Accepts items, gathers encode or decode groups and issues one job per group.
// ----------------------------------------------------------------------------
module b64sc_front
  import b64sc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      mode,
  input  logic      clear,
  input  logic      accept,
  input  src_item_t source,
  output logic      job_push,
  output job_t      job
);

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic        third_was_pad, third_was_pad_next;

  logic [23:0] enc_shift;
  logic [23:0] dec_shift;
  logic        is_pad;
  logic [1:0]  drop;

  assign enc_shift = {group_bits[15:0], source.in_byte};
  assign dec_shift = {group_bits[17:0], char_to_sextet(source.in_byte)};
  assign is_pad    = (source.in_byte == CHAR_PAD);
  assign drop      = {1'b0, source.in_last & is_pad} + {1'b0, source.in_last & third_was_pad};

  // group state and job build
  always_comb begin
    group_bits_next    = group_bits;
    group_count_next   = group_count;
    third_was_pad_next = third_was_pad;
    job_push           = 1'b0;
    job                = '0;
    job.enc            = (mode == MODE_ENCODE);
    if (accept) begin
      if (mode == MODE_ENCODE) begin
        if (group_count == 2'd2) begin
          job_push         = 1'b1;
          job.bits         = enc_shift;
          job.last_idx     = 2'd3;
          job.last         = source.in_last;
          group_bits_next  = '0;
          group_count_next = '0;
        end else if (!source.in_last) begin
          group_bits_next  = enc_shift;
          group_count_next = group_count + 2'd1;
        end else begin
          // flush one or two pending bytes with padding
          job_push     = 1'b1;
          job.last_idx = 2'd3;
          job.last     = 1'b1;
          if (group_count == 2'd0) begin
            job.bits = {source.in_byte, 16'h0000};
            job.pad  = 2'b11;
          end else begin
            job.bits = {group_bits[7:0], source.in_byte, 8'h00};
            job.pad  = 2'b01;
          end
          group_bits_next  = '0;
          group_count_next = '0;
        end
      end else begin
        if (group_count == 2'd2) begin
          third_was_pad_next = is_pad;
        end
        if (group_count != 2'd3) begin
          if (source.in_last) begin
            // short decode stream
            job_push           = 1'b1;
            job.last_idx       = 2'd0;
            job.last           = 1'b1;
            job.bad            = 1'b1;
            group_bits_next    = '0;
            group_count_next   = '0;
            third_was_pad_next = 1'b0;
          end else begin
            group_bits_next  = dec_shift;
            group_count_next = group_count + 2'd1;
          end
        end else begin
          job_push           = 1'b1;
          job.bits           = dec_shift;
          job.last_idx       = 2'd2 - drop;
          job.last           = source.in_last;
          group_bits_next    = '0;
          group_count_next   = '0;
          third_was_pad_next = 1'b0;
        end
      end
    end
    if (clear) begin
      group_bits_next    = '0;
      group_count_next   = '0;
      third_was_pad_next = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits    <= '0;
      group_count   <= '0;
      third_was_pad <= 1'b0;
    end else begin
      group_bits    <= group_bits_next;
      group_count   <= group_count_next;
      third_was_pad <= third_was_pad_next;
    end
  end

endmodule

@@ hw/rtl/b64sc_job_queue.sv @@
// ----------------------------------------------------------------------------
// b64sc_job_queue: job queue
// Small first-in first-out store of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module b64sc_job_queue
  import b64sc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full       = (fill == CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/b64sc_back.sv @@
// ----------------------------------------------------------------------------
// b64sc_back: result emitter
// Walks each job one result per cycle, while the output stage is empty or popped, into that registered stage.
// ----------------------------------------------------------------------------
module b64sc_back
  import b64sc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head,
  output logic      job_pop,
  output logic      empty,
  input  logic      pop,
  output res_item_t result
);

  logic [1:0] idx;
  logic       out_valid;
  logic       load;
  logic [5:0] sextet;
  logic [7:0] dec_byte;
  res_item_t  next_item;

  assign empty   = !out_valid;
  assign load    = head_valid && (!out_valid || pop);
  assign job_pop = load && (idx == head.last_idx);

  // select the result at the current index
  always_comb begin
    case (idx)
      2'd0:    sextet = head.bits[23:18];
      2'd1:    sextet = head.bits[17:12];
      2'd2:    sextet = head.bits[11:6];
      default: sextet = head.bits[5:0];
    endcase
    case (idx)
      2'd0:    dec_byte = head.bits[23:16];
      2'd1:    dec_byte = head.bits[15:8];
      2'd2:    dec_byte = head.bits[7:0];
      default: dec_byte = 8'h00;
    endcase
    next_item            = '0;
    next_item.out_last   = head.last && (idx == head.last_idx);
    next_item.bad_length = head.bad;
    if (head.bad) begin
      next_item.out_byte = 8'h00;
    end else if (head.enc) begin
      if ((idx == 2'd2 && head.pad[1]) || (idx == 2'd3 && head.pad[0])) begin
        next_item.out_byte = CHAR_PAD;
      end else begin
        next_item.out_byte = sextet_to_char(sextet);
      end
    end else begin
      next_item.out_byte = dec_byte;
    end
  end

  // index within the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= job_pop ? 2'd0 : idx + 2'd1;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_item;
    end
  end

endmodule
